// ===== rtl/core/dsp_pkg.sv =====
`default_nettype none

package dsp_pkg;

  localparam int NODE_W = 4;
  localparam int CNT_W  = 5;
  localparam int DIST_W = 24;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7FFFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 24'sh800000;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SELECT,
    ST_DECR,
    ST_RELAX,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              load_edge;
    logic              clear_edges;
    logic              init_run;
    logic              count_en;
    logic              select_en;
    logic              decr_en;
    logic              issue_en;
    logic              emit_en;
    logic              emit_last;
    logic [NODE_W-1:0] node;
  } cmd_t;

  typedef struct packed {
    logic any_ready;
    logic u_reach;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/dsp_ctrl.sv =====
`default_nettype none

module dsp_ctrl import dsp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_accept,
  input  wire logic [1:0]       func,
  input  wire logic [CNT_W-1:0] nc,
  input  wire stat_t            stat,
  output cmd_t                  cmd,
  output logic                  busy
);

  state_t            state, state_next;
  logic [NODE_W-1:0] cnt, cnt_next;
  logic              cnt_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign cnt_last = ({1'b0, cnt} == nc - CNT_W'(1));
  assign busy     = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.node   = cnt;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (func)
            FUNC_LOAD:  cmd.load_edge = 1'b1;
            FUNC_CLEAR: cmd.clear_edges = 1'b1;
            FUNC_RUN: begin
              cmd.init_run = 1'b1;
              cnt_next     = '0;
              state_next   = ST_COUNT;
            end
            default: ;
          endcase
        end
      end
      ST_COUNT: begin
        cmd.count_en = 1'b1;
        if (cnt_last) begin
          state_next = ST_SELECT;
        end else begin
          cnt_next = cnt + NODE_W'(1);
        end
      end
      ST_SELECT: begin
        cmd.select_en = 1'b1;
        cnt_next      = '0;
        state_next    = stat.any_ready ? ST_DECR : ST_EMIT;
      end
      ST_DECR: begin
        cmd.decr_en = 1'b1;
        cnt_next    = '0;
        state_next  = stat.u_reach ? ST_RELAX : ST_SELECT;
      end
      ST_RELAX: begin
        cmd.issue_en = 1'b1;
        if (cnt_last) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + NODE_W'(1);
        end
      end
      ST_DRAIN: begin
        state_next = ST_SELECT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_last = cnt_last;
          if (cnt_last) begin
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + NODE_W'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/dsp_datapath.sv =====
`default_nettype none

module dsp_datapath import dsp_pkg::*; #(
  parameter int NODE_LIMIT  = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  input  wire logic [CNT_W-1:0]         nc,
  input  wire logic [NODE_W-1:0]        edge_from,
  input  wire logic [NODE_W-1:0]        edge_to,
  input  wire logic signed [15:0]       edge_weight,
  input  wire logic [NODE_W-1:0]        source_node,
  input  wire logic                     out_stall,
  output stat_t                         stat,
  output logic                          out_valid,
  output logic [NODE_W-1:0]             node_index,
  output logic signed [DIST_W-1:0]      distance,
  output logic                          reachable,
  output logic                          ordered,
  output logic                          last
);

  localparam int NW   = (NODE_LIMIT > 1) ? $clog2(NODE_LIMIT) : 1;
  localparam int SUMW = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
  localparam int NE   = NODE_LIMIT * NODE_LIMIT;

  logic [NODE_LIMIT-1:0]          adj [NODE_LIMIT];
  logic [CNT_W-1:0]               indeg [NODE_LIMIT];
  logic signed [DIST_W-1:0]       best_dist [NODE_LIMIT];
  logic signed [WEIGHT_BITS-1:0]  cost [NE];
  logic [NODE_LIMIT-1:0]          ord, reach, in_use, ready;
  logic [NW-1:0]                  cur_u, pick, p_col, adj_addr, rd_addr;
  logic                           p_valid;
  logic signed [WEIGHT_BITS-1:0]  cost_q, w_in;
  logic signed [DIST_W-1:0]       du, dist_rd, cand;
  logic signed [SUMW-1:0]         sum;
  logic [NODE_LIMIT-1:0]          adj_row;
  logic                           edge_ok, src_ok, upd;

  generate
    if (WEIGHT_BITS <= 16) begin : g_wnarrow
      assign w_in = edge_weight[WEIGHT_BITS-1:0];
    end else begin : g_wwide
      assign w_in = {{(WEIGHT_BITS-16){1'b0}}, edge_weight};
    end
  endgenerate

  assign edge_ok  = ({1'b0, edge_from} < CNT_W'(NODE_LIMIT)) &&
                    ({1'b0, edge_to} < CNT_W'(NODE_LIMIT));
  assign src_ok   = ({1'b0, source_node} < nc);
  assign adj_addr = cmd.count_en ? cmd.node[NW-1:0] : cur_u;
  assign adj_row  = adj[adj_addr];
  assign rd_addr  = cmd.emit_en ? cmd.node[NW-1:0] : (p_valid ? p_col : cur_u);
  assign dist_rd  = best_dist[rd_addr];

  always_comb begin
    pick = '0;
    for (int i = NODE_LIMIT - 1; i >= 0; i--) begin
      in_use[i] = (CNT_W'(i) < nc);
      ready[i]  = in_use[i] && !ord[i] && (indeg[i] == '0);
      if (ready[i]) pick = NW'(i);
    end
  end

  // Saturating candidate distance through the current node.
  assign sum  = SUMW'(du) + SUMW'(cost_q);
  assign cand = (sum > SUMW'(DIST_MAX)) ? DIST_MAX :
                (sum < SUMW'(DIST_MIN)) ? DIST_MIN : sum[DIST_W-1:0];
  assign upd  = p_valid && adj_row[p_col] && (!reach[p_col] || (cand < dist_rd));

  assign stat.any_ready = |ready;
  assign stat.u_reach   = reach[cur_u];
  assign stat.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODE_LIMIT; i++) adj[i] <= '0;
    end else if (cmd.clear_edges) begin
      for (int i = 0; i < NODE_LIMIT; i++) adj[i] <= '0;
    end else if (cmd.load_edge && edge_ok) begin
      adj[edge_from[NW-1:0]][edge_to[NW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge && edge_ok) begin
      cost[{edge_from[NW-1:0], edge_to[NW-1:0]}] <= w_in;
    end
    if (cmd.issue_en) begin
      cost_q <= cost[{cur_u, cmd.node[NW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reach   <= '0;
      ord     <= '0;
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.issue_en;
      if (cmd.init_run) begin
        ord   <= '0;
        reach <= src_ok ? (NODE_LIMIT'(1) << source_node[NW-1:0]) : '0;
      end else if (cmd.select_en && (|ready)) begin
        ord[pick] <= 1'b1;
      end else if (upd) begin
        reach[p_col] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue_en) p_col <= cmd.node[NW-1:0];
    if (cmd.select_en) cur_u <= pick;
    if (cmd.decr_en) du <= dist_rd;
    for (int i = 0; i < NODE_LIMIT; i++) begin
      if (cmd.init_run) begin
        indeg[i] <= '0;
      end else if (cmd.count_en && in_use[i] && adj_row[i]) begin
        indeg[i] <= indeg[i] + CNT_W'(1);
      end else if (cmd.decr_en && in_use[i] && adj_row[i] && (indeg[i] != '0)) begin
        indeg[i] <= indeg[i] - CNT_W'(1);
      end
    end
    // The source starts at zero if it is a node in use, every other node at infinity.
    for (int i = 0; i < NODE_LIMIT; i++) begin
      if (cmd.init_run) begin
        best_dist[i] <= (src_ok && (source_node[NW-1:0] == NW'(i))) ? '0 : DIST_MAX;
      end else if (upd && (p_col == NW'(i))) begin
        best_dist[i] <= cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      node_index <= cmd.node;
      distance   <= dist_rd;
      reachable  <= reach[cmd.node[NW-1:0]];
      ordered    <= ord[cmd.node[NW-1:0]];
      last       <= cmd.emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dag_shortest_path_engine_core.sv =====
// Single-source shortest paths over a directed graph of up to 16 nodes.
// Input channel (in_valid/in_stall) carries one command per transaction:
// load edge, run from a source node, or clear all edges. Load and clear
// transactions may follow back to back; they give no results. A run raises
// in_stall while the engine works: it counts in-degrees over the nodes in
// use, then per node takes a select step, a decrement step and, for a
// reachable node, a sweep of its row of the single-port edge cost memory
// at one cost read per cycle, then emits one result per node in use.
// Output channel (out_valid/out_stall) delivers one transaction per node in
// use, in node order, with last set on the final one. A registered output
// stage holds each result while out_stall is high; the engine waits for it.
// Reset empties the edge store, sets node_count to the node limit and
// drops any pending result. The user writes node_count (APB port, address 0,
// clamped to 1..limit) only while the engine is idle; nothing enforces it.
`default_nettype none

module dag_shortest_path_engine_core import dsp_pkg::*; #(
  parameter int MAX_NODES   = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             func,
  input  wire logic [3:0]             edge_from,
  input  wire logic [3:0]             edge_to,
  input  wire logic signed [15:0]     edge_weight,
  input  wire logic [3:0]             source_node,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [3:0]                  node_index,
  output logic signed [23:0]          distance,
  output logic                        reachable,
  output logic                        ordered,
  output logic                        last,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int NODE_LIMIT = (MAX_NODES < 16) ? MAX_NODES : 16;

  logic [CNT_W-1:0] node_count;
  logic [CNT_W-1:0] wr_val;
  logic             cfg_wr, in_accept, busy;
  cmd_t             cmd;
  stat_t            stat;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT) &&
                     (paddr[1:0] == 2'b00);
  assign wr_val    = pwdata[CNT_W-1:0];
  assign prdata    = ((paddr[2] == REG_NODE_COUNT) && (paddr[1:0] == 2'b00)) ?
                     {{(32-CNT_W){1'b0}}, node_count} : '0;

  // Clamp the written node count into 1..limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CNT_W'(NODE_LIMIT);
    end else if (cfg_wr) begin
      if (wr_val == '0) begin
        node_count <= CNT_W'(1);
      end else if (wr_val > CNT_W'(NODE_LIMIT)) begin
        node_count <= CNT_W'(NODE_LIMIT);
      end else begin
        node_count <= wr_val;
      end
    end
  end

  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;

  dsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .func      (func),
    .nc        (node_count),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  dsp_datapath #(
    .NODE_LIMIT  (NODE_LIMIT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .nc          (node_count),
    .edge_from   (edge_from),
    .edge_to     (edge_to),
    .edge_weight (edge_weight),
    .source_node (source_node),
    .out_stall   (out_stall),
    .stat        (stat),
    .out_valid   (out_valid),
    .node_index  (node_index),
    .distance    (distance),
    .reachable   (reachable),
    .ordered     (ordered),
    .last        (last)
  );

  // A run transaction always occupies the engine for the following cycle.
  a_run_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == FUNC_RUN) |=> in_stall)
    else $error("run transaction did not stall the input");

  // The final result of a run names the highest node in use.
  a_last_node: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> ({1'b0, node_index} == node_count - CNT_W'(1)))
    else $error("last flag on wrong node");

  // Unreachable nodes report the saturated infinity distance.
  a_unreach_inf: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reachable |-> (distance == DIST_MAX))
    else $error("unreachable node with finite distance");

endmodule

`default_nettype wire
